// ----- rtl/cutrle_pkg.sv -----
// shared types and constants of the run-length scanline decoder
package cutrle_pkg;

    localparam int unsigned IDX_W   = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned BYTES_W = 17;

    localparam logic [2:0] PH_LEN_LO  = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_COUNT   = 3'd2;
    localparam logic [2:0] PH_REPEAT  = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;

    typedef struct packed {
        logic             line_done;
        logic [LEN_W-1:0] run_length;
        logic [IDX_W-1:0] pixel_index;
    } t_run;

endpackage

// ----- rtl/cut_rle_scanline_decoder.sv -----
// run-length scanline decoder: one stream byte in, up to two pixel runs out
//
// channel   dir  tdata                                     tuser/tlast
// s_axis    in   [7:0] stream_byte                         -
// m_axis    out  [7:0] pixel_index, [23:8] run_length      tlast = line_done
// cfg       in   i_cfg_wdata = line_width, i_cfg_we        -
//
// one byte is taken per cycle while the input is ready; its runs go into a
// four-entry result queue; the input is ready while it has room for two runs
// the runs of a byte are registered into the queue on its transfer
// reset (synchronous, active low) empties the queue and waits for a length byte
// a stall on m_axis only holds the input off once three or more runs are queued
module cut_rle_scanline_decoder
    import cutrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [7:0] pixel_index, [23:8] run_length
    output logic        m_axis_tlast
);

    logic [LEN_W-1:0]   r_line_width;
    logic [2:0]         r_phase,     n_phase;
    logic [7:0]         r_len_lo,    n_len_lo;
    logic [LEN_W-1:0]   r_line_len,  n_line_len;
    logic [BYTES_W-1:0] r_bytes,     n_bytes;
    logic [LEN_W-1:0]   r_room,      n_room;
    logic [CNT_W-1:0]   r_run_left,  n_run_left;

    t_run               r_queue [4];
    logic [1:0]         r_wr_ptr;
    logic [1:0]         r_rd_ptr;
    logic [2:0]         r_count;

    t_run               e0;
    t_run               e1;
    logic [1:0]         push;
    logic               s_xfer;
    logic               m_xfer;

    logic [BYTES_W-1:0] bytes_inc;
    logic               bytes_short;
    logic [CNT_W-1:0]   cnt;
    logic [LEN_W-1:0]   run_n;
    logic [LEN_W-1:0]   room_after;
    logic               do_finish;
    logic [IDX_W-1:0]   fin_idx;
    logic [LEN_W-1:0]   new_len;

    assign s_axis_tready = (r_count <= 3'd2);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != 3'd0);
    assign m_xfer        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {r_queue[r_rd_ptr].run_length, r_queue[r_rd_ptr].pixel_index};
    assign m_axis_tlast  = r_queue[r_rd_ptr].line_done;

    assign bytes_inc   = r_bytes + 1'b1;
    assign bytes_short = (bytes_inc < {1'b0, r_line_len});
    assign cnt         = s_axis_tdata[CNT_W-1:0];
    assign new_len     = {s_axis_tdata, r_len_lo};
    assign room_after  = r_room - run_n;

    always_comb begin
        n_phase    = r_phase;
        n_len_lo   = r_len_lo;
        n_line_len = r_line_len;
        n_bytes    = r_bytes;
        n_room     = r_room;
        n_run_left = r_run_left;
        e0         = '0;
        e1         = '0;
        push       = 2'd0;
        do_finish  = 1'b0;
        fin_idx    = s_axis_tdata;
        run_n      = {{(LEN_W-CNT_W){1'b0}}, r_run_left};
        case (r_phase)
            PH_LEN_LO: begin
                n_len_lo = s_axis_tdata;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_line_len = new_len;
                n_bytes    = '0;
                n_run_left = '0;
                n_room     = r_line_width;
                if (r_line_width == '0) begin
                    n_phase = (new_len != '0) ? PH_SKIP : PH_LEN_LO;
                end else if (new_len == '0) begin
                    e0      = '{line_done: 1'b1, run_length: r_line_width, pixel_index: '0};
                    push    = 2'd1;
                    n_phase = PH_LEN_LO;
                end else begin
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n_bytes = bytes_inc;
                if (cnt == '0) begin
                    e0      = '{line_done: 1'b1, run_length: r_room, pixel_index: '0};
                    push    = 2'd1;
                    n_phase = bytes_short ? PH_SKIP : PH_LEN_LO;
                end else begin
                    n_run_left = ({{(LEN_W-CNT_W){1'b0}}, cnt} < r_room) ? cnt
                                                                          : r_room[CNT_W-1:0];
                    n_phase    = s_axis_tdata[7] ? PH_REPEAT : PH_LITERAL;
                end
            end
            PH_REPEAT: begin
                n_bytes    = bytes_inc;
                n_run_left = '0;
                do_finish  = 1'b1;
            end
            PH_LITERAL: begin
                n_bytes = bytes_inc;
                if (r_run_left > 7'd1) begin
                    n_run_left = r_run_left - 1'b1;
                    n_room     = r_room - 1'b1;
                    e0         = '{line_done: 1'b0, run_length: 16'd1,
                                   pixel_index: s_axis_tdata};
                    push       = 2'd1;
                end else begin
                    n_run_left = '0;
                    run_n      = 16'd1;
                    do_finish  = 1'b1;
                end
            end
            PH_SKIP: begin
                n_bytes = bytes_inc;
                if (!bytes_short) begin
                    n_phase = PH_LEN_LO;
                end
            end
            default: begin
                n_phase = PH_LEN_LO;
            end
        endcase

        // run close: queue run; line end if full, fill run if input is used up
        if (do_finish) begin
            n_room = room_after;
            if (room_after == '0) begin
                e0      = '{line_done: 1'b1, run_length: run_n, pixel_index: fin_idx};
                push    = 2'd1;
                n_phase = bytes_short ? PH_SKIP : PH_LEN_LO;
            end else begin
                e0 = '{line_done: 1'b0, run_length: run_n, pixel_index: fin_idx};
                if (!bytes_short) begin
                    e1      = '{line_done: 1'b1, run_length: room_after, pixel_index: '0};
                    push    = 2'd2;
                    n_phase = PH_LEN_LO;
                end else begin
                    push    = 2'd1;
                    n_phase = PH_COUNT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 16'd1;
        end else if (i_cfg_we) begin
            r_line_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN_LO;
            r_len_lo   <= '0;
            r_line_len <= '0;
            r_bytes    <= '0;
            r_room     <= 16'd1;
            r_run_left <= '0;
        end else if (s_xfer) begin
            r_phase    <= n_phase;
            r_len_lo   <= n_len_lo;
            r_line_len <= n_line_len;
            r_bytes    <= n_bytes;
            r_room     <= n_room;
            r_run_left <= n_run_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && push != 2'd0) begin
            r_queue[r_wr_ptr] <= e0;
        end
        if (s_xfer && push == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_xfer) begin
                r_wr_ptr <= r_wr_ptr + push;
            end
            if (m_xfer) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (s_xfer ? {1'b0, push} : 3'd0) - {2'b0, m_xfer};
        end
    end

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // a byte that gives two runs always ends its line on the fill run
    a_two_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && push == 2'd2) |-> (e1.line_done && !e0.line_done))
        else $error("second run without line end");

    // the first queued run of every byte covers at least one pixel
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && push != 2'd0) |-> (e0.run_length != '0))
        else $error("empty run queued");

    // a line in progress always has pixels left
    a_room_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COUNT || r_phase == PH_REPEAT || r_phase == PH_LITERAL)
            |-> (r_room != '0))
        else $error("line open with no room");

endmodule

// ----- tb/cut_rle_scanline_decoder_tb.sv -----
// self-checking testbench for the run-length scanline decoder with its own run predictor
`timescale 1ns / 1ps

module cut_rle_scanline_decoder_tb;
    import cutrle_pkg::*;

    localparam int WATCHDOG     = 2000;
    localparam int SETTLE       = 8;
    localparam int PHASE_BYTES  = 178;
    localparam int RANDOM_PHASES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] stream_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [7:0] pixel_index, [23:8] run_length
    logic        m_axis_tlast;     // line_done

    cut_rle_scanline_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    logic [7:0] stream_q[$];
    t_run       runs_due[$];

    int errors        = 0;
    int bytes_queued  = 0;
    int bytes_sent    = 0;
    int runs_checked  = 0;
    int lines_closed  = 0;
    int width_writes  = 0;
    int quiet_cycles  = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit in_fire       = 1'b0;

    // predictor state
    logic [2:0]  dec_phase;
    logic [7:0]  len_lo_q;
    logic [15:0] enc_len;
    logic [16:0] enc_used;
    logic [16:0] px_done;
    logic [6:0]  run_left_q;
    logic [15:0] width_cfg;
    logic [15:0] width_line;

    task automatic push_run(input logic [7:0] idx, input logic [15:0] n, input logic done);
        t_run r;
        r.pixel_index = idx;
        r.run_length  = n;
        r.line_done   = done;
        runs_due.push_back(r);
    endtask

    task automatic end_line();
        dec_phase = (enc_used < {1'b0, enc_len}) ? PH_SKIP : PH_LEN_LO;
    endtask

    task automatic close_run(input logic [7:0] idx, input logic [16:0] n);
        px_done = px_done + n;
        if (px_done >= {1'b0, width_line}) begin
            push_run(idx, n[15:0], 1'b1);
            end_line();
        end else begin
            push_run(idx, n[15:0], 1'b0);
            if (enc_used >= {1'b0, enc_len}) begin
                push_run(8'h00, 16'({1'b0, width_line} - px_done), 1'b1);
                dec_phase = PH_LEN_LO;
            end else begin
                dec_phase = PH_COUNT;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [6:0]  cnt;
        logic [16:0] room;
        logic [16:0] n;
        case (dec_phase)
            PH_LEN_LO: begin
                len_lo_q  = b;
                dec_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                enc_len    = {b, len_lo_q};
                enc_used   = '0;
                px_done    = '0;
                run_left_q = '0;
                width_line = width_cfg;
                if (width_line == 16'd0) begin
                    end_line();
                end else if (enc_len == 16'd0) begin
                    push_run(8'h00, width_line, 1'b1);
                    dec_phase = PH_LEN_LO;
                end else begin
                    dec_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                enc_used = enc_used + 1'b1;
                cnt      = b[6:0];
                room     = {1'b0, width_line} - px_done;
                if (cnt == 7'd0) begin
                    push_run(8'h00, room[15:0], 1'b1);
                    end_line();
                end else begin
                    run_left_q = ({10'd0, cnt} < room) ? cnt : room[6:0];
                    dec_phase  = b[7] ? PH_REPEAT : PH_LITERAL;
                end
            end
            PH_REPEAT: begin
                enc_used   = enc_used + 1'b1;
                n          = {10'd0, run_left_q};
                run_left_q = '0;
                close_run(b, n);
            end
            PH_LITERAL: begin
                enc_used = enc_used + 1'b1;
                if (run_left_q != 7'd0) run_left_q = run_left_q - 1'b1;
                if (run_left_q != 7'd0) begin
                    px_done = px_done + 1'b1;
                    push_run(b, 16'd1, 1'b0);
                end else begin
                    close_run(b, 17'd1);
                end
            end
            PH_SKIP: begin
                enc_used = enc_used + 1'b1;
                if (enc_used >= {1'b0, enc_len}) dec_phase = PH_LEN_LO;
            end
            default: dec_phase = PH_LEN_LO;
        endcase
    endtask

    // input side: accept at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            decode_byte(s_axis_tdata);
            void'(stream_q.pop_front());
            bytes_sent++;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (stream_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: compare each run transfer with the oldest predicted run
    always @(posedge i_clk) begin : run_check
        t_run got;
        t_run want;
        got.pixel_index = m_axis_tdata[7:0];
        got.run_length  = m_axis_tdata[23:8];
        got.line_done   = m_axis_tlast;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            runs_checked++;
            if (got.line_done) lines_closed++;
            if (runs_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected run: idx %02h len %0d last %0b",
                             got.pixel_index, got.run_length, got.line_done);
                errors++;
            end else begin
                want = runs_due.pop_front();
                if (got.pixel_index !== want.pixel_index || got.run_length !== want.run_length
                        || got.line_done !== want.line_done) begin
                    if (errors < 10)
                        $display({"run %0d mismatch: expected idx %02h len %0d last %0b,",
                                  " got idx %02h len %0d last %0b"},
                                 runs_checked, want.pixel_index, want.run_length,
                                 want.line_done, got.pixel_index, got.run_length,
                                 got.line_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles, %0d runs still pending",
                     WATCHDOG, runs_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(input logic [7:0] b);
        stream_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic write_width(input logic [15:0] w);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        width_cfg    = w;
        width_writes++;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (stream_q.size() != 0 || s_axis_tvalid || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one scanline: mostly well formed, some zero length, padded, cut short or garbage
    task automatic queue_line();
        logic [7:0] body[$];
        int shape;
        int nruns;
        int cnt;
        int pad;
        int len;
        int last_start;
        shape = $urandom_range(99, 0);
        if (shape < 6) begin
            send(8'h00);
            send(8'h00);
            return;
        end
        if (shape < 10) begin
            repeat ($urandom_range(6, 1)) send(8'($urandom_range(255, 0)));
            return;
        end
        nruns      = $urandom_range(5, 1);
        last_start = 0;
        for (int r = 0; r < nruns; r++) begin
            cnt        = ($urandom_range(9, 0) == 0) ? $urandom_range(127, 1)
                                                     : $urandom_range(8, 1);
            last_start = body.size();
            if ($urandom_range(1, 0) == 1) begin
                body.push_back(8'(cnt) | 8'h80);
                body.push_back(8'($urandom_range(255, 0)));
            end else begin
                body.push_back(8'(cnt));
                repeat (cnt) body.push_back(8'($urandom_range(255, 0)));
            end
        end
        if (shape < 60) begin
            len = body.size();
        end else if (shape < 85) begin
            body.push_back(($urandom_range(1, 0) == 1) ? 8'h80 : 8'h00);
            pad = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 100)
                                               : $urandom_range(4, 0);
            repeat (pad) body.push_back(8'($urandom_range(255, 0)));
            len = body.size();
        end else begin
            len = $urandom_range(body.size(), last_start + 1);
        end
        send(8'(len));
        send(8'(len >> 8));
        foreach (body[k]) send(body[k]);
    endtask

    initial begin
        int phase_end;
        logic [15:0] w;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        dec_phase     = PH_LEN_LO;
        len_lo_q      = '0;
        enc_len       = '0;
        enc_used      = '0;
        px_done       = '0;
        run_left_q    = '0;
        width_cfg     = 16'd1;
        width_line    = 16'd1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_width(16'd5);
        // zero length line
        send(8'h00); send(8'h00);
        // repeat then literal, encoded bytes used up short of the width
        send(8'h04); send(8'h00); send(8'h82); send(8'hFF); send(8'h01); send(8'hAA);
        // zero count ends the line, leftovers skipped
        send(8'h03); send(8'h00); send(8'h00); send(8'h11); send(8'h22);
        // literal past the width, line full early, rest skipped
        send(8'h09); send(8'h00); send(8'h07);
        send(8'h01); send(8'h02); send(8'h03); send(8'h04); send(8'h05); send(8'h06);
        send(8'h07); send(8'h80);
        // width change in the middle of a line applies to the next one
        send(8'h02); send(8'h00); send(8'h81);
        wait_drained();
        write_width(16'd9);
        send(8'h33);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case (p)
                0:       w = 16'd1;
                1:       w = 16'hFFFF;
                2:       w = 16'd0;
                3:       w = 16'($urandom_range(16, 2));
                4:       w = 16'($urandom_range(300, 17));
                5:       w = 16'd128;
                6:       w = 16'($urandom_range(40, 2));
                default: w = 16'($urandom_range(65535, 0));
            endcase
            write_width(w);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase
            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end) queue_line();
        end

        wait_drained();
        $display("sent %0d stream bytes under %0d width settings", bytes_sent, width_writes);
        $display("checked %0d runs closing %0d scanlines, %0d mismatches",
                 runs_checked, lines_closed, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cutrle_pkg.sv
rtl/cut_rle_scanline_decoder.sv
tb/cut_rle_scanline_decoder_tb.sv
